// ----- hw/rtl/sed_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types for the string escape decoder: the decode request that the
// front passes to the back through the queue.
// ----------------------------------------------------------------------------
package sed_pkg;

  // One decoded input byte: an optional escape value to emit, then an
  // optional single byte, and the end-of-literal mark.
  typedef struct packed {
    logic        fin_go;
    logic        fin_uni;
    logic        bad;
    logic [20:0] fin_val;
    logic        byte_go;
    logic [7:0]  byte_val;
    logic        last;
  } job_t;

endpackage

// ----- hw/rtl/sed_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sed_front
// Accepts literal body bytes, tracks the escape state and turns each byte
// into at most one decode request for the back end.
// ----------------------------------------------------------------------------
module sed_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_byte,
  input  logic            body_end,
  input  logic            full,
  output logic            push,
  output sed_pkg::job_t   job
);

  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_SLASH = 3'd1;
  localparam logic [2:0] MODE_OCT   = 3'd2;
  localparam logic [2:0] MODE_HEX   = 3'd3;
  localparam logic [2:0] MODE_UNI   = 3'd4;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_LU     = 8'h75;
  localparam logic [7:0] CH_UU     = 8'h55;

  localparam logic [31:0] MAX_CODEPOINT = 32'h0010FFFF;

  logic [2:0]  mode, mode_next;
  logic [31:0] acc, acc_next;
  logic [3:0]  cnt, cnt_next;
  logic        wide, wide_next;

  logic        accept;
  logic        hex_ok, oct_ok, do_plain;
  logic [3:0]  hex_d, cnt_inc;
  logic [31:0] oct_acc, hex_acc, uni_acc;
  logic        fin_go, fin_uni, byte_go;
  logic [31:0] fin_val;
  logic [7:0]  byte_val;

  always_comb begin
    hex_ok = 1'b1;
    hex_d  = '0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_d = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      hex_d = 4'(in_byte - 8'h57);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      hex_d = 4'(in_byte - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign oct_ok  = (in_byte >= 8'h30) && (in_byte <= 8'h37);
  assign cnt_inc = cnt + 4'd1;
  assign oct_acc = {23'b0, acc[5:0], in_byte[2:0]};
  assign hex_acc = {24'b0, acc[3:0], hex_d};
  assign uni_acc = {acc[27:0], hex_d};

  always_comb begin
    mode_next = mode;
    acc_next  = acc;
    cnt_next  = cnt;
    wide_next = wide;
    fin_go    = 1'b0;
    fin_uni   = 1'b0;
    fin_val   = acc;
    byte_go   = 1'b0;
    byte_val  = in_byte;
    do_plain  = 1'b0;

    case (mode)
      MODE_SLASH: begin
        mode_next = MODE_IDLE;
        byte_go   = 1'b1;
        case (in_byte)
          CH_A: byte_val = 8'h07;
          CH_B: byte_val = 8'h08;
          CH_E: byte_val = 8'h1B;
          CH_F: byte_val = 8'h0C;
          CH_N: byte_val = 8'h0A;
          CH_R: byte_val = 8'h0D;
          CH_T: byte_val = 8'h09;
          CH_V: byte_val = 8'h0B;
          CH_X: begin
            byte_go   = 1'b0;
            mode_next = MODE_HEX;
            acc_next  = '0;
            cnt_next  = '0;
          end
          CH_LU, CH_UU: begin
            byte_go   = 1'b0;
            mode_next = MODE_UNI;
            acc_next  = '0;
            cnt_next  = '0;
            wide_next = (in_byte == CH_UU);
          end
          default: begin
            if (oct_ok) begin
              byte_go   = 1'b0;
              mode_next = MODE_OCT;
              acc_next  = {29'b0, in_byte[2:0]};
              cnt_next  = 4'd1;
            end
          end
        endcase
      end
      MODE_OCT: begin
        if (oct_ok) begin
          acc_next = oct_acc;
          cnt_next = cnt_inc;
          if (cnt_inc >= 4'd3) begin
            fin_go    = 1'b1;
            fin_val   = oct_acc;
            mode_next = MODE_IDLE;
            acc_next  = '0;
            cnt_next  = '0;
            wide_next = 1'b0;
          end
        end else begin
          fin_go    = 1'b1;
          mode_next = MODE_IDLE;
          acc_next  = '0;
          cnt_next  = '0;
          wide_next = 1'b0;
          do_plain  = 1'b1;
        end
      end
      MODE_HEX: begin
        if (hex_ok) begin
          acc_next = hex_acc;
        end else begin
          fin_go    = 1'b1;
          mode_next = MODE_IDLE;
          acc_next  = '0;
          cnt_next  = '0;
          wide_next = 1'b0;
          do_plain  = 1'b1;
        end
      end
      MODE_UNI: begin
        fin_uni = 1'b1;
        if (hex_ok) begin
          acc_next = uni_acc;
          cnt_next = cnt_inc;
          if (cnt_inc >= (wide ? 4'd8 : 4'd4)) begin
            fin_go    = 1'b1;
            fin_val   = uni_acc;
            mode_next = MODE_IDLE;
            acc_next  = '0;
            cnt_next  = '0;
            wide_next = 1'b0;
          end
        end else begin
          fin_go    = 1'b1;
          mode_next = MODE_IDLE;
          acc_next  = '0;
          cnt_next  = '0;
          wide_next = 1'b0;
          do_plain  = 1'b1;
        end
      end
      MODE_IDLE: begin
        do_plain = 1'b1;
      end
      default: begin
        mode_next = MODE_IDLE;
        acc_next  = '0;
        cnt_next  = '0;
        wide_next = 1'b0;
        do_plain  = 1'b1;
      end
    endcase

    if (do_plain) begin
      if (in_byte == CH_BSLASH) begin
        mode_next = MODE_SLASH;
      end else begin
        byte_go = 1'b1;
      end
    end

    if (body_end) begin
      if (mode_next == MODE_OCT || mode_next == MODE_HEX || mode_next == MODE_UNI) begin
        fin_go  = 1'b1;
        fin_val = acc_next;
        fin_uni = (mode_next == MODE_UNI);
      end
      mode_next = MODE_IDLE;
      acc_next  = '0;
      cnt_next  = '0;
      wide_next = 1'b0;
    end
  end

  assign in_stall = full;
  assign accept   = in_valid && !full;
  assign push     = accept && (fin_go || byte_go || body_end);

  assign job.fin_go   = fin_go;
  assign job.fin_uni  = fin_uni;
  assign job.bad      = fin_uni && (fin_val > MAX_CODEPOINT);
  assign job.fin_val  = fin_val[20:0];
  assign job.byte_go  = byte_go;
  assign job.byte_val = byte_val;
  assign job.last     = body_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      acc  <= '0;
      cnt  <= '0;
      wide <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      acc  <= acc_next;
      cnt  <= cnt_next;
      wide <= wide_next;
    end
  end

endmodule

// ----- hw/rtl/sed_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sed_queue
// Small request FIFO between front and back; head is read combinationally.
// ----------------------------------------------------------------------------
module sed_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sed_pkg::job_t wr_job,
  input  logic          pop,
  output sed_pkg::job_t rd_job,
  output logic          full,
  output logic          nonempty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sed_pkg::job_t     entries [DEPTH];
  logic [AW-1:0]     wr_ptr, rd_ptr;
  logic [CW-1:0]     count;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign rd_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/sed_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sed_back
// Expands each decode request into output bytes (UTF-8 for code points),
// one per cycle while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module sed_back (
  input  logic          clk,
  input  logic          rst,
  input  sed_pkg::job_t job,
  input  logic          nonempty,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          run_last,
  output logic          literal_done,
  output logic          bad_codepoint,
  output logic          byte_valid
);

  logic [2:0]  idx;
  logic [2:0]  fin_n, total, sum;
  logic [7:0]  u0, u1, u2, u3, utf_sel;
  logic [20:0] v;
  logic        load, is_last;
  logic [7:0]  r_byte;
  logic        r_bv, r_bad;

  assign v = job.fin_val;

  always_comb begin
    u1 = '0;
    u2 = '0;
    u3 = '0;
    if (v < 21'h80) begin
      fin_n = 3'd1;
      u0    = v[7:0];
    end else if (v < 21'h800) begin
      fin_n = 3'd2;
      u0    = {3'b110, v[10:6]};
      u1    = {2'b10, v[5:0]};
    end else if (v < 21'h10000) begin
      fin_n = 3'd3;
      u0    = {4'b1110, v[15:12]};
      u1    = {2'b10, v[11:6]};
      u2    = {2'b10, v[5:0]};
    end else begin
      fin_n = 3'd4;
      u0    = {5'b11110, v[20:18]};
      u1    = {2'b10, v[17:12]};
      u2    = {2'b10, v[11:6]};
      u3    = {2'b10, v[5:0]};
    end
    if (!job.fin_go) begin
      fin_n = 3'd0;
    end else if (!job.fin_uni || job.bad) begin
      fin_n = 3'd1;
    end
  end

  always_comb begin
    case (idx[1:0])
      2'd0:    utf_sel = u0;
      2'd1:    utf_sel = u1;
      2'd2:    utf_sel = u2;
      default: utf_sel = u3;
    endcase
  end

  assign sum     = fin_n + {2'b0, job.byte_go};
  assign total   = (sum == 3'd0) ? 3'd1 : sum;
  assign is_last = (idx == total - 3'd1);

  always_comb begin
    r_byte = '0;
    r_bv   = 1'b0;
    r_bad  = 1'b0;
    if (idx < fin_n) begin
      if (job.bad) begin
        r_bad = 1'b1;
      end else if (job.fin_uni) begin
        r_byte = utf_sel;
        r_bv   = 1'b1;
      end else begin
        r_byte = v[7:0];
        r_bv   = 1'b1;
      end
    end else if (job.byte_go) begin
      r_byte = job.byte_val;
      r_bv   = 1'b1;
    end
  end

  assign load = !out_valid || !out_stall;
  assign pop  = load && nonempty && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= nonempty;
      if (nonempty) begin
        idx <= is_last ? 3'd0 : idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && nonempty) begin
      out_byte      <= r_byte;
      byte_valid    <= r_bv;
      bad_codepoint <= r_bad;
      run_last      <= is_last;
      literal_done  <= is_last && job.last;
    end
  end

endmodule

// ----- hw/rtl/string_escape_decoder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_escape_decoder_top
// C string literal body decoder: escapes, octal/hex values, UTF-8 output.
// ----------------------------------------------------------------------------
// Throughput: one input byte per cycle while the queue is not full; the back
// end sends one result per cycle while out_stall is low; a byte yields up to
// 5 results. The request queue (QDEPTH entries) absorbs bursts between the two.
// Reset (rst, synchronous): escape state idle, queue empty, no result valid.
module string_escape_decoder_top #(
  parameter int QDEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       body_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       literal_done,
  output logic       bad_codepoint,
  output logic       byte_valid
);

  sed_pkg::job_t wr_job, rd_job;
  logic          push, pop, full, nonempty;

  sed_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .body_end (body_end),
    .full     (full),
    .push     (push),
    .job      (wr_job)
  );

  sed_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_job   (wr_job),
    .pop      (pop),
    .rd_job   (rd_job),
    .full     (full),
    .nonempty (nonempty)
  );

  sed_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job           (rd_job),
    .nonempty      (nonempty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .run_last      (run_last),
    .literal_done  (literal_done),
    .bad_codepoint (bad_codepoint),
    .byte_valid    (byte_valid)
  );

endmodule
